// ===== rtl/dpq_pkg.sv =====
// ----------------------------------------------------------------------------
// dpq_pkg
// Shared constants and types for the debug port with host queue.
// ----------------------------------------------------------------------------
package dpq_pkg;

	localparam int HOST_DEPTH      = 8;
	localparam int LOG_BYTES       = 4096;
	localparam int DEBUG_MAX_BYTES = 4096;

	localparam int HOST_AW = $clog2(HOST_DEPTH);
	localparam int HOST_CW = $clog2(HOST_DEPTH + 1);
	localparam int LOG_AW  = $clog2(LOG_BYTES);
	localparam int LOG_CW  = $clog2(LOG_BYTES + 1);
	localparam int DBG_CW  = $clog2(DEBUG_MAX_BYTES + 1);

	localparam logic [31:0] REPLY_PACKET = 32'h3400_0000;
	localparam int          ITEM_HDR     = 12;
	localparam int          ARGC_MAX     = 16;

	// register offsets
	localparam logic [3:0] OFS_DATA  = 4'd0;
	localparam logic [3:0] OFS_ACK   = 4'd8;
	localparam logic [3:0] OFS_CLEAR = 4'd12;

	// packet types
	localparam logic [5:0] PKT_LOG_COUNT = 6'd3;
	localparam logic [5:0] PKT_LOG_DATA  = 6'd4;
	localparam logic [5:0] PKT_DEBUG     = 6'd8;
	localparam logic [5:0] PKT_DEBUG_END = 6'd10;

	// log status codes
	localparam logic [2:0] LOG_NONE      = 3'd0;
	localparam logic [2:0] LOG_COUNT_OK  = 3'd1;
	localparam logic [2:0] LOG_COUNT_BAD = 3'd2;
	localparam logic [2:0] LOG_NO_COUNT  = 3'd3;
	localparam logic [2:0] LOG_DONE      = 3'd4;
	localparam logic [2:0] LOG_MALFORMED = 3'd5;

	// debug status codes
	localparam logic [1:0] DBG_NONE    = 2'd0;
	localparam logic [1:0] DBG_FRAME   = 2'd1;
	localparam logic [1:0] DBG_SHORT   = 2'd2;
	localparam logic [1:0] DBG_BAD_LEN = 2'd3;

	typedef enum logic [2:0] {
		OP_READ_DATA,
		OP_READ_OTHER,
		OP_PACKET,
		OP_ACK,
		OP_CLEAR,
		OP_NOP
	} op_t;

	typedef struct packed {
		op_t         op;
		logic [5:0]  pkt_type;
		logic [1:0]  pkt_len;
		logic [31:0] data;
	} cmd_t;

endpackage

// ===== rtl/debug_port_with_host_queue.sv =====
// ----------------------------------------------------------------------------
// debug_port_with_host_queue
// Debug port: bus access decode, log block check and host reply FIFO.
// ----------------------------------------------------------------------------
// channel  | handshake              | payload
// access   | start, busy            | mode, address, write_data
// result   | done (one-cycle pulse) | read_data, irq_read, irq_write, log_status,
//          |                        | log_count_replaced, log_items, debug_status,
//          |                        | debug_incomplete, host_dropped
//
// A plain access runs S_IDLE, S_DONE; a packet adds S_BYTE per payload byte.
// A full log block is checked item by item in S_C0, S_C1, S_C2 (argc via the
// single log store read port), then S_FIN. Two accesses queue ahead of the
// engine; busy is high while that queue is full. The result receiver cannot
// stall. Reset clears control and port state, not the log store or queue data.
module debug_port_with_host_queue import dpq_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic        mode,
	input  logic [3:0]  address,
	input  logic [31:0] write_data,
	output logic        done,
	output logic [31:0] read_data,
	output logic        irq_read,
	output logic        irq_write,
	output logic [2:0]  log_status,
	output logic        log_count_replaced,
	output logic [8:0]  log_items,
	output logic [1:0]  debug_status,
	output logic        debug_incomplete,
	output logic        host_dropped
);

	logic cmd_valid;
	logic cmd_take;
	cmd_t cmd;

	// access intake and queue
	dpq_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (start),
		.mode       (mode),
		.address    (address),
		.write_data (write_data),
		.busy       (busy),
		.cmd_valid  (cmd_valid),
		.cmd        (cmd),
		.cmd_take   (cmd_take)
	);

	// execution engine
	dpq_back u_back (
		.clk                (clk),
		.arst_n             (arst_n),
		.cmd_valid          (cmd_valid),
		.cmd                (cmd),
		.cmd_take           (cmd_take),
		.done               (done),
		.read_data          (read_data),
		.irq_read           (irq_read),
		.irq_write          (irq_write),
		.log_status         (log_status),
		.log_count_replaced (log_count_replaced),
		.log_items          (log_items),
		.debug_status       (debug_status),
		.debug_incomplete   (debug_incomplete),
		.host_dropped       (host_dropped)
	);

endmodule

// ===== rtl/dpq_front.sv =====
// ----------------------------------------------------------------------------
// dpq_front
// Accepts bus accesses, classifies them and holds them in a two-entry queue.
// ----------------------------------------------------------------------------
module dpq_front import dpq_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic        mode,
	input  logic [3:0]  address,
	input  logic [31:0] write_data,
	output logic        busy,
	output logic        cmd_valid,
	output cmd_t        cmd,
	input  logic        cmd_take
);

	cmd_t       entry_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] count_q;
	cmd_t       cls;
	logic       push;
	logic       pop;

	// classify the access
	always_comb begin
		cls.pkt_type = write_data[31:26];
		cls.pkt_len  = write_data[25:24];
		cls.data     = write_data;
		if (!mode) begin
			cls.op = (address == OFS_DATA) ? OP_READ_DATA : OP_READ_OTHER;
		end else begin
			unique case (address)
				OFS_DATA:  cls.op = OP_PACKET;
				OFS_ACK:   cls.op = OP_ACK;
				OFS_CLEAR: cls.op = OP_CLEAR;
				default:   cls.op = OP_NOP;
			endcase
		end
	end

	assign busy      = (count_q == 2'd2);
	assign push      = start && !busy;
	assign cmd_valid = (count_q != 2'd0);
	assign pop       = cmd_valid && cmd_take;
	assign cmd       = entry_q[rd_ptr_q];

	// queue payload
	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= cls;
		end
	end

	// queue pointers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push) wr_ptr_q <= !wr_ptr_q;
			if (pop) rd_ptr_q <= !rd_ptr_q;
			count_q <= count_q + 2'(push) - 2'(pop);
		end
	end

endmodule

// ===== rtl/dpq_back.sv =====
// ----------------------------------------------------------------------------
// dpq_back
// Carries out queued accesses: packet decode, log store and check, host FIFO.
// ----------------------------------------------------------------------------
module dpq_back import dpq_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cmd_valid,
	input  cmd_t        cmd,
	output logic        cmd_take,
	output logic        done,
	output logic [31:0] read_data,
	output logic        irq_read,
	output logic        irq_write,
	output logic [2:0]  log_status,
	output logic        log_count_replaced,
	output logic [8:0]  log_items,
	output logic [1:0]  debug_status,
	output logic        debug_incomplete,
	output logic        host_dropped
);

	typedef enum logic [2:0] {
		S_IDLE, S_BYTE, S_C0, S_C1, S_C2, S_FIN, S_DONE
	} state_t;

	state_t              state_q;
	cmd_t                cur_q;
	logic [1:0]          n_q;
	logic [31:0]         latched_q;
	logic [31:0]         fifo_q [HOST_DEPTH];
	logic [HOST_AW-1:0]  head_q, tail_q;
	logic [HOST_CW-1:0]  fill_q;
	logic                irq_rd_q, irq_wr_q;
	logic [23:0]         cnt_bytes_q;
	logic [1:0]          cnt_idx_q;
	logic [LOG_CW-1:0]   log_exp_q, log_rcv_q;
	logic [7:0]          store [LOG_BYTES];
	logic [LOG_AW-1:0]   rd_addr;
	logic [7:0]          mem_rd_q;
	logic [7:0]          hi_q;
	logic [31:0]         len_bytes_q;
	logic [2:0]          len_idx_q;
	logic [DBG_CW-1:0]   dbg_exp_q, dbg_rcv_q;
	logic [LOG_CW-1:0]   off_q;
	logic                bad_q;
	logic                done_q;
	logic [31:0]         rdata_q;
	logic [2:0]          lstat_q;
	logic                repl_q;
	logic [8:0]          items_q;
	logic [1:0]          dstat_q;
	logic                dinc_q;
	logic                drop_q;

	logic [7:0]          pbyte;
	logic [23:0]         cb_next;
	logic [31:0]         lb_next;
	logic [DBG_CW-1:0]   rcv_next;
	logic [LOG_CW-1:0]   log_rcv_next;
	logic                last_byte;
	logic                log_open;
	logic                store_wr;
	logic [LOG_CW:0]     off_hdr;
	logic [15:0]         argc;
	logic [17:0]         item_size;
	logic [18:0]         item_end;

	assign cmd_take = (state_q == S_IDLE) && cmd_valid;

	// current payload byte and derived values
	always_comb begin
		case (n_q)
			2'd0:    pbyte = cur_q.data[23:16];
			2'd1:    pbyte = cur_q.data[15:8];
			default: pbyte = cur_q.data[7:0];
		endcase
		cb_next      = {cnt_bytes_q[15:0], pbyte};
		lb_next      = {len_bytes_q[23:0], pbyte};
		rcv_next     = dbg_rcv_q + DBG_CW'(1);
		log_rcv_next = log_rcv_q + LOG_CW'(1);
		last_byte    = (n_q == cur_q.pkt_len - 2'd1);
		log_open     = (log_exp_q != '0) && (log_rcv_q < log_exp_q);
		store_wr     = (state_q == S_BYTE) && (cur_q.pkt_type == PKT_LOG_DATA)
			&& (log_rcv_q < LOG_CW'(LOG_BYTES));
		off_hdr      = {1'b0, off_q} + (LOG_CW+1)'(ITEM_HDR);
		argc         = {hi_q, mem_rd_q};
		item_size    = ({2'b0, argc} + 18'd3) << 2;
		item_end     = 19'(off_q) + {1'b0, item_size};
		rd_addr      = (state_q == S_C1) ? LOG_AW'(off_q + LOG_CW'(9))
			: LOG_AW'(off_q + LOG_CW'(8));
	end

	// log store
	always_ff @(posedge clk) begin
		if (store_wr) begin
			store[log_rcv_q[LOG_AW-1:0]] <= pbyte;
		end
		mem_rd_q <= store[rd_addr];
	end

	// host fifo payload
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < HOST_DEPTH; i++) fifo_q[i] <= '0;
		end else if (state_q == S_FIN && fill_q < HOST_CW'(HOST_DEPTH)) begin
			fifo_q[tail_q] <= REPLY_PACKET;
		end
	end

	// sequencer and all port state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			cur_q       <= '0;
			n_q         <= '0;
			latched_q   <= '0;
			head_q      <= '0;
			tail_q      <= '0;
			fill_q      <= '0;
			irq_rd_q    <= 1'b0;
			irq_wr_q    <= 1'b0;
			cnt_bytes_q <= '0;
			cnt_idx_q   <= '0;
			log_exp_q   <= '0;
			log_rcv_q   <= '0;
			len_bytes_q <= '0;
			len_idx_q   <= '0;
			dbg_exp_q   <= '0;
			dbg_rcv_q   <= '0;
			off_q       <= '0;
			bad_q       <= 1'b0;
			hi_q        <= '0;
			done_q      <= 1'b0;
			rdata_q     <= '0;
			lstat_q     <= LOG_NONE;
			repl_q      <= 1'b0;
			items_q     <= '0;
			dstat_q     <= DBG_NONE;
			dinc_q      <= 1'b0;
			drop_q      <= 1'b0;
		end else begin
			done_q <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (cmd_valid) begin
						cur_q   <= cmd;
						n_q     <= '0;
						rdata_q <= '0;
						lstat_q <= LOG_NONE;
						repl_q  <= 1'b0;
						items_q <= '0;
						dstat_q <= DBG_NONE;
						dinc_q  <= 1'b0;
						drop_q  <= 1'b0;
						state_q <= S_DONE;
						unique case (cmd.op)
							OP_READ_DATA: begin
								rdata_q <= (fill_q != '0) ? fifo_q[head_q] : latched_q;
							end
							OP_ACK: begin
								if (fill_q != '0) begin
									head_q <= (head_q == HOST_AW'(HOST_DEPTH - 1))
										? '0 : head_q + HOST_AW'(1);
									fill_q <= fill_q - HOST_CW'(1);
								end
								irq_wr_q <= (fill_q > HOST_CW'(1));
							end
							OP_CLEAR: irq_rd_q <= 1'b0;
							OP_PACKET: begin
								latched_q <= cmd.data;
								irq_rd_q  <= 1'b1;
								if (cmd.pkt_type == PKT_DEBUG_END) begin
									if (len_idx_q != '0 || dbg_rcv_q != '0) begin
										dinc_q    <= 1'b1;
										len_idx_q <= '0;
										dbg_rcv_q <= '0;
										dbg_exp_q <= '0;
									end
								end else if (cmd.pkt_len != 2'd0) begin
									if (cmd.pkt_type == PKT_LOG_DATA && log_exp_q == '0) begin
										lstat_q <= LOG_NO_COUNT;
									end else if (cmd.pkt_type == PKT_LOG_COUNT
										|| cmd.pkt_type == PKT_LOG_DATA
										|| cmd.pkt_type == PKT_DEBUG) begin
										state_q <= S_BYTE;
									end
								end
							end
							default: ;
						endcase
					end
				end
				// one payload byte per cycle
				S_BYTE: begin
					n_q <= n_q + 2'd1;
					state_q <= last_byte ? S_DONE : S_BYTE;
					if (cur_q.pkt_type == PKT_LOG_COUNT) begin
						cnt_bytes_q <= cb_next;
						cnt_idx_q   <= cnt_idx_q + 2'd1;
						if (cnt_idx_q == 2'd2) begin
							cnt_idx_q <= '0;
							if (log_open) repl_q <= 1'b1;
							if (cb_next == '0 || cb_next > 24'(LOG_BYTES)) begin
								lstat_q <= LOG_COUNT_BAD;
								if (log_open) begin
									log_exp_q <= '0;
									log_rcv_q <= '0;
								end
							end else begin
								lstat_q   <= LOG_COUNT_OK;
								log_exp_q <= cb_next[LOG_CW-1:0];
								log_rcv_q <= '0;
							end
						end
					end else if (cur_q.pkt_type == PKT_LOG_DATA) begin
						log_rcv_q <= log_rcv_next;
						if (last_byte && log_rcv_next >= log_exp_q) begin
							off_q   <= '0;
							bad_q   <= 1'b0;
							state_q <= S_C0;
						end
					end else begin
						if (len_idx_q < 3'd4) begin
							len_bytes_q <= lb_next;
							len_idx_q   <= len_idx_q + 3'd1;
							if (len_idx_q == 3'd3) begin
								dbg_rcv_q <= '0;
								if (lb_next == '0 || lb_next > 32'(DEBUG_MAX_BYTES)) begin
									dstat_q   <= DBG_BAD_LEN;
									len_idx_q <= '0;
									dbg_exp_q <= '0;
								end else begin
									dbg_exp_q <= lb_next[DBG_CW-1:0];
								end
							end
						end else if (rcv_next < dbg_exp_q) begin
							dbg_rcv_q <= rcv_next;
						end else begin
							dstat_q   <= (dbg_exp_q < DBG_CW'(12)) ? DBG_SHORT : DBG_FRAME;
							len_idx_q <= '0;
							dbg_rcv_q <= '0;
							dbg_exp_q <= '0;
						end
					end
				end
				// block check: header fits, fetch argc
				S_C0: begin
					if (off_hdr <= {1'b0, log_exp_q}) begin
						state_q <= S_C1;
					end else begin
						if (off_q != log_exp_q) bad_q <= 1'b1;
						state_q <= S_FIN;
					end
				end
				S_C1: begin
					hi_q    <= mem_rd_q;
					state_q <= S_C2;
				end
				S_C2: begin
					if (argc > 16'(ARGC_MAX) || item_end > 19'(log_exp_q)) begin
						bad_q   <= 1'b1;
						state_q <= S_FIN;
					end else begin
						items_q <= items_q + 9'd1;
						off_q   <= item_end[LOG_CW-1:0];
						state_q <= S_C0;
					end
				end
				// block complete: queue the reply, or flag a drop if the host FIFO is full
				S_FIN: begin
					log_exp_q <= '0;
					log_rcv_q <= '0;
					lstat_q   <= bad_q ? LOG_MALFORMED : LOG_DONE;
					if (fill_q < HOST_CW'(HOST_DEPTH)) begin
						tail_q   <= (tail_q == HOST_AW'(HOST_DEPTH - 1))
							? '0 : tail_q + HOST_AW'(1);
						fill_q   <= fill_q + HOST_CW'(1);
						irq_wr_q <= 1'b1;
					end else begin
						drop_q <= 1'b1;
					end
					state_q <= S_DONE;
				end
				S_DONE: begin
					done_q  <= 1'b1;
					state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign done               = done_q;
	assign read_data          = rdata_q;
	assign irq_read           = irq_rd_q;
	assign irq_write          = irq_wr_q;
	assign log_status         = lstat_q;
	assign log_count_replaced = repl_q;
	assign log_items          = items_q;
	assign debug_status       = dstat_q;
	assign debug_incomplete   = dinc_q;
	assign host_dropped       = drop_q;

endmodule
